### rtl/core/rtnp_pkg.sv
`default_nettype none

package rtnp_pkg;

    localparam int CHAR_W = 8;
    localparam int VAL_W  = 16;

    typedef enum logic [1:0] {
        PH_START,
        PH_DIGIT,
        PH_OCTAVE,
        PH_SHARP
    } t_phase;

    typedef struct packed {
        logic [VAL_W-1:0] divisor;
        logic [VAL_W-1:0] duration;
        logic             last;
    } t_note;

    localparam logic [CHAR_W-1:0] CH_END   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_SHARP = 8'h23;
    localparam logic [CHAR_W-1:0] CH_REST  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_1     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_2     = 8'h32;
    localparam logic [CHAR_W-1:0] CH_3     = 8'h33;
    localparam logic [CHAR_W-1:0] CH_4     = 8'h34;
    localparam logic [CHAR_W-1:0] CH_6     = 8'h36;
    localparam logic [CHAR_W-1:0] CH_8     = 8'h38;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
    localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
    localparam logic [CHAR_W-1:0] CH_E     = 8'h65;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
    localparam logic [CHAR_W-1:0] CH_G     = 8'h67;

    localparam logic [3:0] ROW_NONE = 4'hF;
    localparam logic [3:0] ROW_E    = 4'd4;
    localparam logic [3:0] ROW_B    = 4'd11;
    localparam logic [3:0] ROWS     = 4'd12;
    localparam logic [3:0] OCTAVES  = 4'd9;

    localparam logic [VAL_W-1:0] DUR_1  = 16'd33333;
    localparam logic [VAL_W-1:0] DUR_2  = 16'd16666;
    localparam logic [VAL_W-1:0] DUR_4  = 16'd8333;
    localparam logic [VAL_W-1:0] DUR_8  = 16'd4166;
    localparam logic [VAL_W-1:0] DUR_16 = 16'd2083;
    localparam logic [VAL_W-1:0] DUR_32 = 16'd1041;

    localparam logic [VAL_W-1:0] TONE_TABLE [0:11][0:8] = '{
        '{16'd2039, 16'd1019, 16'd510, 16'd255, 16'd127, 16'd64, 16'd32, 16'd16, 16'd8},
        '{16'd1924, 16'd962,  16'd481, 16'd240, 16'd120, 16'd60, 16'd30, 16'd15, 16'd8},
        '{16'd1817, 16'd908,  16'd454, 16'd227, 16'd114, 16'd57, 16'd28, 16'd14, 16'd7},
        '{16'd1714, 16'd857,  16'd428, 16'd214, 16'd107, 16'd54, 16'd27, 16'd13, 16'd7},
        '{16'd1618, 16'd809,  16'd405, 16'd202, 16'd101, 16'd51, 16'd25, 16'd13, 16'd0},
        '{16'd1527, 16'd763,  16'd382, 16'd191, 16'd95,  16'd48, 16'd24, 16'd12, 16'd0},
        '{16'd1442, 16'd721,  16'd360, 16'd180, 16'd90,  16'd45, 16'd23, 16'd11, 16'd0},
        '{16'd1361, 16'd680,  16'd340, 16'd170, 16'd85,  16'd43, 16'd21, 16'd11, 16'd0},
        '{16'd1286, 16'd643,  16'd321, 16'd161, 16'd80,  16'd40, 16'd20, 16'd10, 16'd0},
        '{16'd1212, 16'd606,  16'd303, 16'd152, 16'd76,  16'd38, 16'd19, 16'd9,  16'd0},
        '{16'd1144, 16'd572,  16'd286, 16'd143, 16'd76,  16'd36, 16'd18, 16'd9,  16'd0},
        '{16'd1080, 16'd540,  16'd270, 16'd135, 16'd67,  16'd34, 16'd17, 16'd8,  16'd0}
    };

    function automatic logic [3:0] letter_row(input logic [CHAR_W-1:0] ch);
        logic [3:0] row;
        case (ch)
            CH_C:    row = 4'd0;
            CH_D:    row = 4'd2;
            CH_E:    row = 4'd4;
            CH_F:    row = 4'd5;
            CH_G:    row = 4'd7;
            CH_A:    row = 4'd9;
            CH_B:    row = 4'd11;
            default: row = ROW_NONE;
        endcase
        return row;
    endfunction

    function automatic logic [VAL_W-1:0] tone_lookup(input logic [3:0] row,
                                                     input logic [3:0] col);
        logic [VAL_W-1:0] v;
        v = '0;
        if (row < ROWS && col < OCTAVES) begin
            v = TONE_TABLE[row][col];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ringtone_note_parser_unit.sv
// Channel   Direction  Ports              Beat contents
// s         in         i_s_t*, o_s_tready tdata[7:0] char_code
// m         out        o_m_t*, i_m_tready tdata[15:0] tone_divisor, [31:16] note_duration,
//                                         tlast end_of_tune
//
// One character is taken every cycle unless the result beat stalls; o_m_tvalid comes from the
// result register, fed from the input register via the parse state update and tone table lookup.
// Synchronous active-low reset returns the parser to token start with duration and divisor zero.
// A stalled result beat holds the full input register, which in turn holds o_s_tready low.
`default_nettype none

module ringtone_note_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] char_code
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [15:0] tone_divisor, [31:16] note_duration
    output logic             o_m_tlast
);

    logic                        in_valid;
    logic [rtnp_pkg::CHAR_W-1:0] in_char;
    logic                        can_load;
    logic                        step;
    logic                        emit;
    rtnp_pkg::t_note             note;

    assign step = in_valid && can_load;

    rtnp_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_step     (step),
        .o_valid    (in_valid),
        .o_char     (in_char)
    );

    rtnp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_char  (in_char),
        .o_emit  (emit),
        .o_note  (note)
    );

    rtnp_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_emit     (emit),
        .i_note     (note),
        .o_can_load (can_load),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

### rtl/core/rtnp_in_stage.sv
`default_nettype none

module rtnp_in_stage (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    input  wire logic [rtnp_pkg::CHAR_W-1:0] i_s_tdata,
    input  wire logic                       i_step,
    output logic                            o_valid,
    output logic [rtnp_pkg::CHAR_W-1:0]     o_char
);

    logic                        r_valid;
    logic [rtnp_pkg::CHAR_W-1:0] r_char;

    assign o_s_tready = !r_valid || i_step;
    assign o_valid    = r_valid;
    assign o_char     = r_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_char <= i_s_tdata;
        end
    end

endmodule

`default_nettype wire

### rtl/core/rtnp_parser.sv
`default_nettype none

module rtnp_parser (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [rtnp_pkg::CHAR_W-1:0] i_char,
    output logic                            o_emit,
    output rtnp_pkg::t_note                 o_note
);

    rtnp_pkg::t_phase             r_phase, n_phase;
    logic [rtnp_pkg::CHAR_W-1:0]  r_pend, n_pend;
    logic                         r_sharp, n_sharp;
    logic [rtnp_pkg::VAL_W-1:0]   r_dur, n_dur;
    logic [rtnp_pkg::VAL_W-1:0]   r_div, n_div;
    logic                         plain;
    logic                         last;
    logic [3:0]                   row;
    logic [3:0]                   col;
    logic [rtnp_pkg::CHAR_W-1:0]  ch_off;
    logic [rtnp_pkg::VAL_W-1:0]   tone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rtnp_pkg::PH_START;
            r_pend  <= '0;
            r_sharp <= 1'b0;
            r_dur   <= '0;
            r_div   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_sharp <= n_sharp;
            r_dur   <= n_dur;
            r_div   <= n_div;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_pend  = r_pend;
        n_sharp = r_sharp;
        n_dur   = r_dur;
        n_div   = r_div;
        o_emit  = 1'b0;
        last    = 1'b0;
        plain   = 1'b0;
        ch_off  = i_char - rtnp_pkg::CH_1;
        col     = ch_off[3:0];
        row     = rtnp_pkg::letter_row(r_pend);
        if (r_sharp && row != rtnp_pkg::ROW_E && row != rtnp_pkg::ROW_B
            && row != rtnp_pkg::ROW_NONE) begin
            row = row + 4'd1;
        end
        tone = rtnp_pkg::tone_lookup(row, col);

        case (r_phase)
            rtnp_pkg::PH_DIGIT: begin
                n_phase = rtnp_pkg::PH_START;
                if (r_pend == rtnp_pkg::CH_1 && i_char == rtnp_pkg::CH_6) begin
                    n_dur = rtnp_pkg::DUR_16;
                end else if (r_pend == rtnp_pkg::CH_3 && i_char == rtnp_pkg::CH_2) begin
                    n_dur = rtnp_pkg::DUR_32;
                end else begin
                    if (i_char != rtnp_pkg::CH_SPACE) begin
                        case (r_pend)
                            rtnp_pkg::CH_1: n_dur = rtnp_pkg::DUR_1;
                            rtnp_pkg::CH_2: n_dur = rtnp_pkg::DUR_2;
                            rtnp_pkg::CH_4: n_dur = rtnp_pkg::DUR_4;
                            rtnp_pkg::CH_8: n_dur = rtnp_pkg::DUR_8;
                            default:        n_dur = r_dur;
                        endcase
                    end
                    plain = 1'b1;
                end
            end
            rtnp_pkg::PH_SHARP: begin
                if (i_char inside {rtnp_pkg::CH_C, rtnp_pkg::CH_D, rtnp_pkg::CH_F,
                                   rtnp_pkg::CH_G, rtnp_pkg::CH_A}) begin
                    n_pend  = i_char;
                    n_sharp = 1'b1;
                    n_phase = rtnp_pkg::PH_OCTAVE;
                end else begin
                    plain = 1'b1;
                end
            end
            rtnp_pkg::PH_OCTAVE: begin
                n_phase = rtnp_pkg::PH_START;
                n_sharp = 1'b0;
                if (row != rtnp_pkg::ROW_NONE
                    && i_char inside {[rtnp_pkg::CH_1:rtnp_pkg::CH_9]}
                    && tone != '0) begin
                    n_div = tone;
                end
                if (i_char == rtnp_pkg::CH_END) begin
                    o_emit = 1'b1;
                    last   = 1'b1;
                end
            end
            default: begin
                plain = 1'b1;
            end
        endcase

        if (plain) begin
            n_phase = rtnp_pkg::PH_START;
            if (i_char == rtnp_pkg::CH_SPACE) begin
                o_emit = 1'b1;
            end else if (i_char == rtnp_pkg::CH_END) begin
                o_emit = 1'b1;
                last   = 1'b1;
            end else if (i_char inside {rtnp_pkg::CH_1, rtnp_pkg::CH_2, rtnp_pkg::CH_3,
                                        rtnp_pkg::CH_4, rtnp_pkg::CH_8}) begin
                n_pend  = i_char;
                n_phase = rtnp_pkg::PH_DIGIT;
            end else if (i_char == rtnp_pkg::CH_REST) begin
                n_div = n_dur;
            end else if (i_char == rtnp_pkg::CH_SHARP) begin
                n_phase = rtnp_pkg::PH_SHARP;
            end else if (rtnp_pkg::letter_row(i_char) != rtnp_pkg::ROW_NONE) begin
                n_pend  = i_char;
                n_sharp = 1'b0;
                n_phase = rtnp_pkg::PH_OCTAVE;
            end
        end

        if (last) begin
            n_phase = rtnp_pkg::PH_START;
            n_pend  = '0;
            n_sharp = 1'b0;
        end

        o_note.divisor  = n_div;
        o_note.duration = n_dur;
        o_note.last     = last;
    end

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_emit && o_note.last) |=> (r_phase == rtnp_pkg::PH_START && !r_sharp))
        else $error("parser not back at token start after end of tune");

    a_octave_one_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == rtnp_pkg::PH_OCTAVE) |=> (r_phase == rtnp_pkg::PH_START))
        else $error("octave slot held for more than one character");

    a_octave_emit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && r_phase == rtnp_pkg::PH_OCTAVE) |-> o_note.last)
        else $error("note emitted from octave slot without end of tune");

endmodule

`default_nettype wire

### rtl/core/rtnp_out_stage.sv
`default_nettype none

module rtnp_out_stage (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_step,
    input  wire logic                           i_emit,
    input  wire rtnp_pkg::t_note                i_note,
    output logic                                o_can_load,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [2*rtnp_pkg::VAL_W-1:0]        o_m_tdata,
    output logic                                o_m_tlast
);

    logic            r_valid;
    rtnp_pkg::t_note r_note;

    assign o_can_load = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_note.duration, r_note.divisor};
    assign o_m_tlast  = r_note.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step && i_emit) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_emit) begin
            r_note <= i_note;
        end
    end

endmodule

`default_nettype wire
